// ===== hw/rtl/rsdq_pkg.sv =====
// rsdq_pkg: shared types and codes for the reversible sortable deque
// used by the interface file and every module of the block
`default_nettype none
package rsdq_pkg;
  localparam int unsigned DEPTH_DEF = 32;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned KIND_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_NOP        = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_PUSH_BACK  = 3'd3,
    FN_POP_BACK   = 3'd4,
    FN_REVERSE    = 3'd5,
    FN_DUMP       = 3'd6,
    FN_SORT       = 3'd7
  } func_t;

  localparam logic [KIND_W-1:0] KIND_COUNT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ELEM  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR   = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic signed [DATA_W-1:0] data;
    logic last;
  } res_t;

  // signed less-than
  function automatic logic lt_signed(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    lt_signed = $signed(a) < $signed(b);
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/rsdq_if.sv =====
// rsdq_if: valid/ready channels (command and result), each carrying one beat of payload
// depends on rsdq_pkg for the payload widths
`default_nettype none
interface rsdq_cmd_if;
  import rsdq_pkg::*;
  logic valid;
  logic ready;
  logic [FUNC_W-1:0] func;
  logic signed [DATA_W-1:0] value;
  modport source (output valid, func, value, input ready);
  modport sink (input valid, func, value, output ready);
endinterface

interface rsdq_res_if;
  import rsdq_pkg::*;
  logic valid;
  logic ready;
  logic [KIND_W-1:0] kind;
  logic signed [DATA_W-1:0] data;
  logic last;
  modport source (output valid, kind, data, last, input ready);
  modport sink (input valid, kind, data, last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rsdq_ram.sv =====
// rsdq_ram: element store, one write port and one registered read port
// depends on rsdq_pkg for the data width
`default_nettype none
module rsdq_ram #(
  parameter int unsigned DEPTH = rsdq_pkg::DEPTH_DEF,
  parameter int unsigned AW = 5
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [rsdq_pkg::DATA_W-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output      logic [rsdq_pkg::DATA_W-1:0] rdata
);
  import rsdq_pkg::*;
  logic [DATA_W-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/rsdq_ctrl.sv =====
// rsdq_ctrl: command sequencer: pointers, dump walk, bubble sort passes
// depends on rsdq_pkg, rsdq_if and drives rsdq_ram through its ports
`default_nettype none
module rsdq_ctrl #(
  parameter int unsigned DEPTH = rsdq_pkg::DEPTH_DEF,
  parameter int unsigned AW = 5,
  parameter int unsigned CW = 6
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rsdq_cmd_if.sink in_ch,
  rsdq_res_if.source out_ch,
  output      logic we,
  output      logic [AW-1:0] waddr,
  output      logic [rsdq_pkg::DATA_W-1:0] wdata,
  output      logic [AW-1:0] raddr,
  input  wire logic [rsdq_pkg::DATA_W-1:0] rdata
);
  import rsdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DREAD, S_DOUT, S_SREAD, S_SCMP, S_SWAIT
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic rev_r, rev_nxt;
  logic [CW-1:0] idx_r, idx_nxt;   // walk position
  logic [CW-1:0] pass_r, pass_nxt; // sort passes left
  logic swp_r, swp_nxt;            // swap seen in this pass
  logic [DATA_W-1:0] prev_r, prev_nxt;
  logic ov_r, ov_nxt;
  res_t ob_r, ob_nxt;

  // physical slot of logical offset i from head
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(i);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    slot = s[AW-1:0];
  endfunction

  logic in_acc, ob_free;
  assign ob_free = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && ob_free;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = ov_r;
  assign out_ch.kind = ob_r.kind;
  assign out_ch.data = ob_r.data;
  assign out_ch.last = ob_r.last;

  always_comb begin
    logic side;
    logic [CW-1:0] ridx;
    state_nxt = state_r; head_nxt = head_r; cnt_nxt = cnt_r; rev_nxt = rev_r;
    idx_nxt = idx_r; pass_nxt = pass_r; swp_nxt = swp_r; prev_nxt = prev_r;
    ov_nxt = ov_r && !out_ch.ready; ob_nxt = ob_r;
    we = 1'b0; waddr = '0; wdata = in_ch.value; raddr = slot(head_r, idx_r);
    side = 1'b0; ridx = '0;
    unique case (state_r)
      S_IDLE: if (in_acc) begin
        unique case (func_t'(in_ch.func))
          FN_PUSH_FRONT, FN_PUSH_BACK: begin
            if (cnt_r >= CW'(DEPTH)) begin
              ov_nxt = 1'b1; ob_nxt = '{KIND_ERR, '0, 1'b1};
            end else begin
              side = (in_ch.func == FN_PUSH_BACK) ^ rev_r;
              we = 1'b1;
              if (!side) begin
                head_nxt = slot(head_r, CW'(DEPTH - 1));
                waddr = head_nxt;
              end else waddr = slot(head_r, cnt_r);
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          FN_POP_FRONT, FN_POP_BACK: begin
            if (cnt_r == '0) begin
              ov_nxt = 1'b1; ob_nxt = '{KIND_ERR, '0, 1'b1};
            end else begin
              side = (in_ch.func == FN_POP_BACK) ^ rev_r;
              if (!side) head_nxt = slot(head_r, CW'(1));
              cnt_nxt = cnt_r - 1'b1;
            end
          end
          FN_REVERSE: rev_nxt = !rev_r;
          FN_DUMP: begin
            ov_nxt = 1'b1;
            ob_nxt = '{KIND_COUNT, DATA_W'(cnt_r), cnt_r == '0};
            idx_nxt = '0;
            if (cnt_r != '0) state_nxt = S_DREAD;
          end
          FN_SORT: begin
            rev_nxt = 1'b0;
            if (cnt_r > CW'(1)) begin
              pass_nxt = cnt_r - 1'b1; idx_nxt = '0; swp_nxt = 1'b0;
              state_nxt = S_SREAD;
            end
          end
          default: ;
        endcase
      end
      S_DREAD: begin
        ridx = rev_r ? (cnt_r - 1'b1 - idx_r) : idx_r;
        raddr = slot(head_r, ridx);
        state_nxt = S_DOUT;
      end
      S_DOUT: begin
        // keep the read address so the element survives a stalled result
        ridx = rev_r ? (cnt_r - 1'b1 - idx_r) : idx_r;
        raddr = slot(head_r, ridx);
        if (ob_free) begin
          ov_nxt = 1'b1;
          ob_nxt = '{KIND_ELEM, rdata, (idx_r + 1'b1) == cnt_r};
          idx_nxt = idx_r + 1'b1;
          state_nxt = ((idx_r + 1'b1) == cnt_r) ? S_IDLE : S_DREAD;
        end
      end
      S_SREAD: begin
        raddr = slot(head_r, idx_r);
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        // idx_r element now in rdata; compare with previous
        if (idx_r != '0 && lt_signed(rdata, prev_r)) begin
          we = 1'b1; waddr = slot(head_r, idx_r - 1'b1); wdata = rdata;
          swp_nxt = 1'b1;
          // prev stays the larger value, written into idx_r below
          state_nxt = S_SWAIT;
        end else begin
          prev_nxt = rdata;
          if (idx_r == pass_r) begin
            pass_nxt = pass_r - 1'b1; idx_nxt = '0; swp_nxt = 1'b0;
            state_nxt = (!swp_r || pass_r == CW'(1)) ? S_IDLE : S_SREAD;
          end else begin
            idx_nxt = idx_r + 1'b1; state_nxt = S_SREAD;
          end
        end
      end
      S_SWAIT: begin
        we = 1'b1; waddr = slot(head_r, idx_r); wdata = prev_r;
        if (idx_r == pass_r) begin
          pass_nxt = pass_r - 1'b1; idx_nxt = '0; swp_nxt = 1'b0;
          state_nxt = (pass_r == CW'(1)) ? S_IDLE : S_SREAD;
        end else begin
          idx_nxt = idx_r + 1'b1; state_nxt = S_SREAD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; head_r <= '0; cnt_r <= '0; rev_r <= 1'b0;
      idx_r <= '0; pass_r <= '0; swp_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; head_r <= head_nxt; cnt_r <= cnt_nxt; rev_r <= rev_nxt;
      idx_r <= idx_nxt; pass_r <= pass_nxt; swp_r <= swp_nxt; ov_r <= ov_nxt;
    end
    prev_r <= prev_nxt;
    ob_r <= ob_nxt;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/reversible_sortable_deque.sv =====
// reversible_sortable_deque: top level, store memory plus command sequencer
// depends on rsdq_pkg, rsdq_if, rsdq_ram, rsdq_ctrl
//
//  channel | dir | beat carries
//  in_     | in  | func, value
//  out_    | out | kind, data, last
//
// push, pop, reverse: at most one store write each
// dump: count beat, then per element a store read (S_DREAD) and an element beat (S_DOUT)
// sort: bubble passes; per compare S_SREAD, S_SCMP and on a swap S_SWAIT; up to n*n/2 compares
// reset clears state, pointers, count and flags; store contents need no clearing
// out_ready low stalls the dump walk; in_ready is low while a dump or sort walk runs
`default_nettype none
module reversible_sortable_deque #(
  parameter int unsigned DEPTH = rsdq_pkg::DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output      logic in_ready,
  input  wire logic [rsdq_pkg::FUNC_W-1:0] in_func,
  input  wire logic signed [rsdq_pkg::DATA_W-1:0] in_value,
  output      logic out_valid,
  input  wire logic out_ready,
  output      logic [rsdq_pkg::KIND_W-1:0] out_kind,
  output      logic signed [rsdq_pkg::DATA_W-1:0] out_data,
  output      logic out_last
);
  import rsdq_pkg::*;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rsdq_cmd_if cmd_ch ();
  rsdq_res_if res_ch ();

  assign cmd_ch.valid = in_valid;
  assign cmd_ch.func = in_func;
  assign cmd_ch.value = in_value;
  assign in_ready = cmd_ch.ready;
  assign out_valid = res_ch.valid;
  assign out_kind = res_ch.kind;
  assign out_data = res_ch.data;
  assign out_last = res_ch.last;
  assign res_ch.ready = out_ready;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;

  rsdq_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  rsdq_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_ch(cmd_ch), .out_ch(res_ch),
    .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // a stalled result beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_kind))
    else $error("result beat changed under stall");
  // an error beat is always the final one and carries zero
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERR |-> out_last && out_data == '0)
    else $error("bad error beat");
  // no new command while a beat waits unaccepted
  a_nocmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("command taken under stall");
endmodule
`default_nettype wire
